// ----- rtl/otsu_pkg.sv -----
// Shared constants, operation codes and controller/datapath bundles for the Otsu
// threshold block. Has no dependencies. Every other file of the block imports it.
package otsu_pkg;

  localparam int BINS_DEF       = 256;
  localparam int COUNT_BITS_DEF = 22;
  localparam int PIXEL_W        = 8;
  localparam int LEVEL_W        = 8;

  typedef logic [2:0] op_t;

  // Multiplications done for each candidate split.
  localparam op_t OP_SBW = 3'd0;  // sB * W
  localparam op_t OP_SWB = 3'd1;  // S * wB
  localparam op_t OP_DD  = 3'd2;  // D * D
  localparam op_t OP_DEN = 3'd3;  // wB * (W - wB)
  localparam op_t OP_LHS = 3'd4;  // D^2 * best denominator
  localparam op_t OP_RHS = 3'd5;  // best numerator * denominator

  typedef struct packed {
    logic rd_pix;      // memory read address comes from the incoming pixel
    logic mem_clr;     // write zero at the sweep index
    logic add_pix;     // increment the captured bin and the pixel total
    logic cap_pix;     // capture the pixel's bin index
    logic load_cls;    // load a classify word into the output register
    logic load_rep;    // load the report, set the level, clear the pass count
    logic idx_clr;
    logic idx_inc;
    logic sweep_init;  // clear the sweep accumulators and the best candidate
    logic acc_sum;     // add idx * bin into the total weighted sum
    logic acc_pass;    // add the bin into wB and idx * bin into sB
    logic mul_start;
    op_t  op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic idx_last;
    logic wb_zero;
    logic wb_reach;
    logic mul_done;
    logic out_free;
  } ctrl_stat_t;

endpackage

// ----- rtl/otsu_if.sv -----
// Handshake channels of the Otsu threshold block: pixel words in, result words out.
// Depends on otsu_pkg for the field widths.
interface otsu_in_if import otsu_pkg::*;;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [PIXEL_W-1:0] pixel;
  logic               last;

  modport source (output valid, cmd, pixel, last, input ready);
  modport sink   (input valid, cmd, pixel, last, output ready);
endinterface

interface otsu_out_if import otsu_pkg::*;;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [LEVEL_W-1:0] level;
  logic               white;
  logic               overflow;

  modport source (output valid, kind, level, white, overflow, input ready);
  modport sink   (input valid, kind, level, white, overflow, output ready);
endinterface

// ----- rtl/otsu_mul.sv -----
// Shift-and-add multiplier, one multiplier bit per cycle.
// Depends on otsu_pkg only for the house import; widths come from parameters.
module otsu_mul import otsu_pkg::*; #(
  parameter int PW = 148,
  parameter int MW = 52
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [PW-1:0] a,
  input  logic [MW-1:0] b,
  output logic [PW-1:0] prod,
  output logic          done
);

  localparam int CW = $clog2(MW + 1);

  logic [PW-1:0] acc;
  logic [PW-1:0] a_sh;
  logic [MW-1:0] b_sh;
  logic [CW-1:0] cnt;
  logic          busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == CW'(1))) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc  <= '0;
      a_sh <= a;
      b_sh <= b;
      cnt  <= CW'(MW);
    end else if (busy) begin
      if (b_sh[0]) begin
        acc <= acc + a_sh;
      end
      a_sh <= a_sh << 1;
      b_sh <= b_sh >> 1;
      cnt  <= cnt - CW'(1);
    end
  end

  assign prod = acc;

endmodule

// ----- rtl/otsu_dp.sv -----
// Datapath: histogram memory, pass count, sweep accumulators, best candidate
// and output register. Depends on otsu_pkg, otsu_if and otsu_mul.
module otsu_dp import otsu_pkg::*; #(
  parameter int BINS       = BINS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  ctrl_cmd_t          cmd,
  output ctrl_stat_t         st,
  input  logic [PIXEL_W-1:0] pixel,
  otsu_out_if.source         res
);

  localparam int IW  = $clog2(BINS);
  localparam int CB  = COUNT_BITS;
  localparam int SW  = CB + 2 * IW;
  localparam int WBW = CB + IW;
  localparam int DW  = SW + CB;
  localparam int PW  = 2 * DW + 2 * CB;
  localparam int MW  = DW;
  localparam logic [CB-1:0] CNT_MAX = {CB{1'b1}};

  logic [CB-1:0]      mem [BINS];
  logic [CB-1:0]      rd_data;
  logic [IW-1:0]      rd_addr;
  logic [IW-1:0]      wr_addr;
  logic [CB-1:0]      wr_data;
  logic               mem_we;
  logic [IW-1:0]      pix_bin;
  logic [IW-1:0]      pix_idx;
  logic [IW-1:0]      idx;
  logic [CB-1:0]      total;
  logic               sat;
  logic [LEVEL_W-1:0] level_reg;
  logic [SW-1:0]      sum_all;
  logic [WBW-1:0]     wb;
  logic [WBW-1:0]     wb_next;
  logic [SW-1:0]      sb;
  logic [WBW-1:0]     ibin;
  logic [DW-1:0]      x;
  logic [DW-1:0]      y;
  logic [DW-1:0]      d;
  logic [2*DW-1:0]    d2;
  logic [2*CB-1:0]    den;
  logic [PW-1:0]      lhs;
  logic [2*DW-1:0]    best_num;
  logic [2*CB-1:0]    best_den;
  logic [IW-1:0]      thr;
  logic [PW-1:0]      mul_a;
  logic [MW-1:0]      mul_b;
  logic [PW-1:0]      prod;
  logic               mul_done;
  logic               out_valid;
  logic               out_kind;
  logic [LEVEL_W-1:0] out_level;
  logic               out_white;
  logic               out_ovf;

  // Pixels beyond the last bin fall into it.
  always_comb begin
    if (32'(pixel) > BINS - 1) begin
      pix_bin = IW'(BINS - 1);
    end else begin
      pix_bin = IW'(pixel);
    end
  end

  assign rd_addr = cmd.rd_pix ? pix_bin : idx;
  assign mem_we  = cmd.mem_clr || cmd.add_pix;
  assign wr_addr = cmd.add_pix ? pix_idx : idx;
  assign wr_data = cmd.add_pix ? ((rd_data == CNT_MAX) ? rd_data : rd_data + CB'(1)) : '0;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  assign ibin    = WBW'(idx) * WBW'(rd_data);
  assign wb_next = wb + WBW'(rd_data);
  assign y       = DW'(prod);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_SBW: begin
        mul_a = PW'(sb);
        mul_b = MW'(total);
      end
      OP_SWB: begin
        mul_a = PW'(sum_all);
        mul_b = MW'(wb);
      end
      OP_DD: begin
        mul_a = PW'(d);
        mul_b = MW'(d);
      end
      OP_DEN: begin
        mul_a = PW'(wb);
        mul_b = MW'(total - wb[CB-1:0]);
      end
      OP_LHS: begin
        mul_a = PW'(d2);
        mul_b = MW'(best_den);
      end
      OP_RHS: begin
        mul_a = PW'(best_num);
        mul_b = MW'(den);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  otsu_mul #(.PW(PW), .MW(MW)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (prod),
    .done  (mul_done)
  );

  // Control state: index, pass count and its saturation flag, stored level and the output flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      total     <= '0;
      sat       <= 1'b0;
      level_reg <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.idx_clr || cmd.sweep_init) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + IW'(1);
      end
      if (cmd.add_pix) begin
        if (total != CNT_MAX) begin
          total <= total + CB'(1);
        end
        if (total >= CNT_MAX - CB'(1)) begin
          sat <= 1'b1;
        end
      end
      if (cmd.load_rep) begin
        level_reg <= LEVEL_W'(thr);
        total     <= '0;
        sat       <= 1'b0;
      end
      if (cmd.load_cls || cmd.load_rep) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_pix) begin
      pix_idx <= pix_bin;
    end
    if (cmd.sweep_init) begin
      sum_all  <= '0;
      wb       <= '0;
      sb       <= '0;
      best_num <= '0;
      best_den <= (2*CB)'(1);
      thr      <= '0;
    end
    if (cmd.acc_sum) begin
      sum_all <= sum_all + SW'(ibin);
    end
    if (cmd.acc_pass) begin
      wb <= wb_next;
      sb <= sb + SW'(ibin);
    end
    if (mul_done) begin
      case (cmd.op)
        OP_SBW: x <= DW'(prod);
        OP_SWB: d <= (x >= y) ? x - y : y - x;
        OP_DD:  d2 <= (2*DW)'(prod);
        OP_DEN: den <= (2*CB)'(prod);
        OP_LHS: lhs <= prod;
        OP_RHS: begin
          if (lhs > prod) begin
            best_num <= d2;
            best_den <= den;
            thr      <= idx;
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd.load_cls) begin
      out_kind  <= 1'b1;
      out_level <= level_reg;
      out_white <= pixel >= level_reg;
      out_ovf   <= sat;
    end else if (cmd.load_rep) begin
      out_kind  <= 1'b0;
      out_level <= LEVEL_W'(thr);
      out_white <= 1'b0;
      out_ovf   <= sat;
    end
  end

  assign res.valid    = out_valid;
  assign res.kind     = out_kind;
  assign res.level    = out_level;
  assign res.white    = out_white;
  assign res.overflow = out_ovf;

  assign st.idx_last = idx == IW'(BINS - 1);
  assign st.wb_zero  = wb_next == '0;
  assign st.wb_reach = wb_next >= WBW'(total);
  assign st.mul_done = mul_done;
  assign st.out_free = !out_valid || res.ready;

endmodule

// ----- rtl/otsu_ctrl.sv -----
// Controller state machine: pixel handling, the two bin sweeps, the multiply
// sequence per candidate, the report and the memory clear. Depends on otsu_pkg.
module otsu_ctrl import otsu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_cmd,
  input  logic       in_last,
  output logic       in_ready,
  input  ctrl_stat_t st,
  output ctrl_cmd_t  cmd
);

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_ADD    = 4'd2;
  localparam logic [3:0] ST_S1RD   = 4'd3;
  localparam logic [3:0] ST_S1ACC  = 4'd4;
  localparam logic [3:0] ST_P2RD   = 4'd5;
  localparam logic [3:0] ST_P2ACC  = 4'd6;
  localparam logic [3:0] ST_P2NEXT = 4'd7;
  localparam logic [3:0] ST_MSTART = 4'd8;
  localparam logic [3:0] ST_MWAIT  = 4'd9;
  localparam logic [3:0] ST_REPORT = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;
  op_t        op;
  op_t        op_next;
  logic       last_r;
  logic       accept;

  assign accept = in_valid && in_ready;

  always_comb begin
    state_next = state;
    op_next    = op;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.op     = op;
    unique case (state)
      ST_CLEAR: begin
        cmd.mem_clr = 1'b1;
        if (st.idx_last) begin
          state_next = ST_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      ST_IDLE: begin
        cmd.rd_pix = 1'b1;
        in_ready   = st.out_free;
        if (accept) begin
          if (in_cmd) begin
            cmd.load_cls = 1'b1;
          end else begin
            cmd.cap_pix = 1'b1;
            state_next  = ST_ADD;
          end
        end
      end
      ST_ADD: begin
        cmd.add_pix = 1'b1;
        if (last_r) begin
          cmd.sweep_init = 1'b1;
          state_next     = ST_S1RD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_S1RD: begin
        state_next = ST_S1ACC;
      end
      ST_S1ACC: begin
        cmd.acc_sum = 1'b1;
        if (st.idx_last) begin
          cmd.idx_clr = 1'b1;
          state_next  = ST_P2RD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = ST_S1RD;
        end
      end
      ST_P2RD: begin
        state_next = ST_P2ACC;
      end
      ST_P2ACC: begin
        cmd.acc_pass = 1'b1;
        if (st.wb_reach) begin
          state_next = ST_REPORT;
        end else if (st.wb_zero) begin
          state_next = ST_P2NEXT;
        end else begin
          op_next    = OP_SBW;
          state_next = ST_MSTART;
        end
      end
      ST_P2NEXT: begin
        if (st.idx_last) begin
          state_next = ST_REPORT;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = ST_P2RD;
        end
      end
      ST_MSTART: begin
        cmd.mul_start = 1'b1;
        state_next    = ST_MWAIT;
      end
      ST_MWAIT: begin
        if (st.mul_done) begin
          if (op == OP_RHS) begin
            state_next = ST_P2NEXT;
          end else begin
            op_next    = op + op_t'(1);
            state_next = ST_MSTART;
          end
        end
      end
      ST_REPORT: begin
        if (st.out_free) begin
          cmd.load_rep = 1'b1;
          cmd.idx_clr  = 1'b1;
          state_next   = ST_CLEAR;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_CLEAR;
      op     <= OP_SBW;
      last_r <= 1'b0;
    end else begin
      state <= state_next;
      op    <= op_next;
      if (accept) begin
        last_r <= in_last;
      end
    end
  end

endmodule

// ----- rtl/otsu_histogram_threshold.sv -----
// Top level of the Otsu threshold block: joins the controller and the datapath.
// Depends on otsu_pkg, otsu_if, otsu_ctrl and otsu_dp.
//
//   channel   direction  word fields
//   pixels    in         cmd (1), pixel (8), last (1)
//   results   out        kind (1), level (8), white (1), overflow (1)
//
// A classify word is handled in the idle state alone; an add word also passes
// through the add state (read, then write back the bin in the histogram memory).
// An add word with last set starts the threshold search: a first sweep over the
// bins forms the weighted sum, then a second sweep runs, for each candidate split,
// six shift-add multiplies of DW bits each (DW = 2*COUNT_BITS + 2*log2(BINS)).
// After the report the histogram is cleared bin by bin; the same clear runs
// after reset, and no word is taken while it runs.
// Words are refused while a result waits in the output register and is not taken.
module otsu_histogram_threshold import otsu_pkg::*; #(
  parameter int BINS       = BINS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  otsu_in_if.sink    pixels,
  otsu_out_if.source results
);

  ctrl_cmd_t  ccmd;
  ctrl_stat_t cstat;

  // The controller sequences everything; it sees only status from the datapath.
  otsu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pixels.valid),
    .in_cmd   (pixels.cmd),
    .in_last  (pixels.last),
    .in_ready (pixels.ready),
    .st       (cstat),
    .cmd      (ccmd)
  );

  // The datapath holds the histogram, the sums, the multiplier and the result word.
  otsu_dp #(
    .BINS       (BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk   (clk),
    .rst   (rst),
    .cmd   (ccmd),
    .st    (cstat),
    .pixel (pixels.pixel),
    .res   (results)
  );

`ifndef NO_ASSERTIONS
  // An add word occupies the block for its write-back cycle.
  a_add_busy: assert property (@(posedge clk) disable iff (rst)
    (pixels.valid && pixels.ready && !pixels.cmd) |=> !pixels.ready)
    else $error("word taken right after an add word");

  // A classify word shows up in the output register on the next cycle.
  a_cls_out: assert property (@(posedge clk) disable iff (rst)
    (pixels.valid && pixels.ready && pixels.cmd) |=> (results.valid && results.kind))
    else $error("classify result missing");

  // A multiply never finishes in the cycle after it starts.
  a_mul_len: assert property (@(posedge clk) disable iff (rst)
    ccmd.mul_start |=> !cstat.mul_done)
    else $error("multiplier finished too early");
`endif

endmodule

// ----- bench/tb_otsu_histogram_threshold.sv -----
// Self-checking bench for otsu_histogram_threshold: histogram passes and classify words.
// Depends on otsu_pkg, the otsu_in_if / otsu_out_if channels and the top level of the RTL.
`timescale 1ns / 100ps

module tb_otsu_histogram_threshold;
  import otsu_pkg::*;

  // Word codes on the two channels.
  localparam logic CMD_ADD     = 1'b0;
  localparam logic CMD_CLASSIFY = 1'b1;
  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_PIXEL  = 1'b1;

  localparam int          NBINS     = BINS_DEF;
  localparam longint      COUNT_MAX = (64'd1 << COUNT_BITS_DEF) - 1;
  localparam int          PHASE_WORDS = 500;

  typedef struct packed {
    logic               kind;
    logic [LEVEL_W-1:0] level;
    logic               white;
    logic               overflow;
  } result_t;

  // One row of the directed part. Where has_fixed is set the expected result
  // is typed in; otherwise the predictor decides.
  typedef struct {
    logic               cmd;
    logic [PIXEL_W-1:0] pixel;
    logic               last;
    logic               has_fixed;
    result_t            fixed;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  otsu_in_if  pix_if ();
  otsu_out_if res_if ();

  otsu_histogram_threshold u_dut (
    .clk     (clk),
    .rst     (rst),
    .pixels  (pix_if),
    .results (res_if)
  );

  always #6 clk = ~clk;

  // Predictor state: our own copy of the histogram and the threshold.
  longint unsigned    hist [NBINS];
  longint unsigned    pass_total;
  logic               pass_saturated;
  logic [LEVEL_W-1:0] cur_level;

  result_t pending_results [$];
  int      errors;
  int      pct_in_idle;
  int      pct_out_stall;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Otsu search over the gathered histogram. Variances D^2/(wB*wF) are compared
  // by cross-multiplication at 256 bits, so nothing is rounded.
  function automatic logic [LEVEL_W-1:0] otsu_level();
    logic [255:0]    best_num, best_den, x, y, d, d2, den, lhs, rhs;
    longint unsigned weighted_sum, wb, sb;
    logic [LEVEL_W-1:0] thr;
    weighted_sum = 0;
    wb = 0;
    sb = 0;
    thr = '0;
    best_num = '0;
    best_den = 256'd1;
    for (int i = 0; i < NBINS; i++) weighted_sum += longint'(i) * hist[i];
    for (int i = 0; i < NBINS; i++) begin
      wb += hist[i];
      if (wb == 0) continue;
      if (wb >= pass_total) break;
      sb += longint'(i) * hist[i];
      x = 256'(sb) * 256'(pass_total);
      y = 256'(weighted_sum) * 256'(wb);
      d = (x >= y) ? x - y : y - x;
      d2 = d * d;
      den = 256'(wb * (pass_total - wb));
      lhs = d2 * best_den;
      rhs = best_num * den;
      if (lhs > rhs) begin
        best_num = d2;
        best_den = den;
        thr = LEVEL_W'(i);
      end
    end
    return thr;
  endfunction

  // Applies one accepted word to the predictor; returns 1 when a result follows.
  function automatic bit predict_word(input logic cmd, input logic [PIXEL_W-1:0] pixel,
                                      input logic last, output result_t res);
    res = '0;
    if (cmd == CMD_CLASSIFY) begin
      res.kind = KIND_PIXEL;
      res.level = cur_level;
      res.white = (pixel >= cur_level);
      res.overflow = pass_saturated;
      return 1;
    end
    if (hist[pixel] < COUNT_MAX) hist[pixel]++;
    if (pass_total < COUNT_MAX) pass_total++;
    if (pass_total >= COUNT_MAX) pass_saturated = 1'b1;
    if (!last) return 0;
    cur_level = otsu_level();
    res.kind = KIND_REPORT;
    res.level = cur_level;
    res.white = 1'b0;
    res.overflow = pass_saturated;
    foreach (hist[i]) hist[i] = 0;
    pass_total = 0;
    pass_saturated = 1'b0;
    return 1;
  endfunction

  // Drives one word at the falling edge, with a random gap in front of it, and
  // holds it until the block takes it at a rising edge.
  task automatic send_word(input logic cmd, input logic [PIXEL_W-1:0] pixel,
                           input logic last, input bit has_fixed, input result_t fixed);
    result_t predicted;
    bit      has_result;
    @(negedge clk);
    while ($urandom_range(99) < pct_in_idle) begin
      pix_if.valid = 1'b0;
      @(negedge clk);
    end
    pix_if.valid = 1'b1;
    pix_if.cmd   = cmd;
    pix_if.pixel = pixel;
    pix_if.last  = last;
    do @(posedge clk); while (!pix_if.ready);
    has_result = predict_word(cmd, pixel, last, predicted);
    if (has_fixed) begin
      // The typed-in value must agree with the predictor too.
      if (predicted != fixed) report_mismatch("directed row vs predictor", predicted, fixed);
      pending_results.push_back(fixed);
    end else if (has_result) begin
      pending_results.push_back(predicted);
    end
  endtask

  // A histogram pass of len pixels drawn from [base, base+span], with a few
  // classify words mixed in (some with last set, which must be ignored).
  task automatic random_pass(input int len, input int base, input int span, inout int words);
    int p;
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(7) == 0) begin
        send_word(CMD_CLASSIFY, PIXEL_W'($urandom_range(255)), 1'($urandom_range(1)),
                  1'b0, '0);
        words++;
      end
      p = base + $urandom_range(span);
      if (p > 255) p = 255;
      send_word(CMD_ADD, PIXEL_W'(p), k == len - 1, 1'b0, '0);
      words++;
    end
  endtask

  task automatic random_phase(input int in_idle, input int out_stall, input bit wide_pass);
    int words;
    int base;
    pct_in_idle = in_idle;
    pct_out_stall = out_stall;
    words = 0;
    // One full-range pass in a phase with wide_pass set; the sweep is slow across many bins.
    if (wide_pass) random_pass(40, 0, 255, words);
    while (words < PHASE_WORDS) begin
      base = $urandom_range(255);
      random_pass($urandom_range(1, 24), base, $urandom_range(1, 12), words);
    end
  endtask

  // Receiver: random stalls, decided at the falling edge.
  always @(negedge clk) begin
    res_if.ready <= ($urandom_range(99) >= pct_out_stall);
  end

  // Every taken result is compared with the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result word, pending", 0, 1);
      end else begin
        want = pending_results.pop_front();
        if (res_if.kind !== want.kind) report_mismatch("kind", res_if.kind, want.kind);
        if (res_if.level !== want.level) report_mismatch("level", res_if.level, want.level);
        if (res_if.white !== want.white) report_mismatch("white", res_if.white, want.white);
        if (res_if.overflow !== want.overflow)
          report_mismatch("overflow", res_if.overflow, want.overflow);
      end
    end
  end

  // Directed rows: reset state, extremes, both commands, last ignored on
  // classify, a one-pixel pass, a pass within a single bin, a two-end pass.
  row_t rows [] = '{
    '{CMD_CLASSIFY, 8'd0,   1'b0, 1'b1, '{KIND_PIXEL,  8'd0, 1'b1, 1'b0}},
    '{CMD_CLASSIFY, 8'd255, 1'b0, 1'b1, '{KIND_PIXEL,  8'd0, 1'b1, 1'b0}},
    '{CMD_CLASSIFY, 8'd0,   1'b1, 1'b1, '{KIND_PIXEL,  8'd0, 1'b1, 1'b0}},
    '{CMD_ADD,      8'd77,  1'b1, 1'b1, '{KIND_REPORT, 8'd0, 1'b0, 1'b0}},
    '{CMD_ADD,      8'd10,  1'b0, 1'b0, '0},
    '{CMD_ADD,      8'd10,  1'b0, 1'b0, '0},
    '{CMD_ADD,      8'd200, 1'b1, 1'b0, '0},
    '{CMD_CLASSIFY, 8'd9,   1'b0, 1'b0, '0},
    '{CMD_CLASSIFY, 8'd10,  1'b0, 1'b0, '0},
    '{CMD_CLASSIFY, 8'd255, 1'b1, 1'b0, '0},
    '{CMD_ADD,      8'd0,   1'b0, 1'b0, '0},
    '{CMD_ADD,      8'd255, 1'b1, 1'b0, '0},
    '{CMD_CLASSIFY, 8'd0,   1'b0, 1'b0, '0},
    '{CMD_ADD,      8'd255, 1'b0, 1'b0, '0},
    '{CMD_ADD,      8'd255, 1'b0, 1'b0, '0},
    '{CMD_ADD,      8'd255, 1'b1, 1'b1, '{KIND_REPORT, 8'd0, 1'b0, 1'b0}},
    '{CMD_ADD,      8'd0,   1'b0, 1'b0, '0},
    '{CMD_ADD,      8'd128, 1'b0, 1'b0, '0},
    '{CMD_ADD,      8'd127, 1'b0, 1'b0, '0},
    '{CMD_ADD,      8'd255, 1'b1, 1'b0, '0},
    '{CMD_CLASSIFY, 8'd127, 1'b0, 1'b0, '0},
    '{CMD_CLASSIFY, 8'd128, 1'b0, 1'b0, '0}
  };

  initial begin
    pix_if.valid = 1'b0;
    pix_if.cmd   = CMD_ADD;
    pix_if.pixel = '0;
    pix_if.last  = 1'b0;
    res_if.ready = 1'b0;
    foreach (hist[i]) hist[i] = 0;
    pass_total = 0;
    pass_saturated = 1'b0;
    cur_level = '0;
    errors = 0;
    pct_in_idle = 0;
    pct_out_stall = 0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part, with light idling on both sides.
    pct_in_idle = 20;
    pct_out_stall = 20;
    foreach (rows[i])
      send_word(rows[i].cmd, rows[i].pixel, rows[i].last, rows[i].has_fixed, rows[i].fixed);

    random_phase(33, 51, 1'b1);
    random_phase(51, 33, 1'b1);
    random_phase(0, 0, 1'b0);

    @(negedge clk);
    pix_if.valid = 1'b0;

    // Drain, then leave room for the histogram clear after the last report.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #240_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/otsu_pkg.sv
rtl/otsu_if.sv
rtl/otsu_mul.sv
rtl/otsu_dp.sv
rtl/otsu_ctrl.sv
rtl/otsu_histogram_threshold.sv
bench/tb_otsu_histogram_threshold.sv
